// File: rtl/assert_macros.svh
// Assertion macros for the RTL files of the combination generator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cgen_pkg.sv
// Shared types, constants and helper functions of the combination generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cgen_pkg;

    localparam int POS_W       = 4;
    localparam int MASK_W      = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DEF_MAX_POSITIONS = 16;
    localparam int DEF_VALUE_BITS    = 32;

    localparam logic [CNT_W-1:0] TOTAL_RESET  = 5'd16;
    localparam logic [CNT_W-1:0] CHOOSE_RESET = 5'd1;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_NEXT    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        JOB_LOAD = 2'd0,
        JOB_EMIT = 2'd1,
        JOB_DONE = 2'd2
    } t_job_kind;

    typedef enum logic {
        REG_TOTAL  = 1'b0,
        REG_CHOOSE = 1'b1
    } t_reg;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

    typedef struct packed {
        t_job_kind          kind;
        logic [POS_W-1:0]   index;
        logic [DATA_W-1:0]  value;
        logic [MASK_W-1:0]  mask;
    } t_job;

    function automatic logic [MASK_W-1:0] f_low_ones(input logic [CNT_W-1:0] cnt);
        logic [MASK_W:0] full;
        full = (17'd1 << cnt) - 17'd1;
        return full[MASK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/cgen_front.sv
// Front end: accepts input requests, keeps the selection mask and builds jobs.
// Depends on cgen_pkg; feeds cgen_fifo.
`default_nettype none

module cgen_front #(
    parameter int MAX_POSITIONS = cgen_pkg::DEF_MAX_POSITIONS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [cgen_pkg::CNT_W-1:0]  i_total,
    input  wire logic [cgen_pkg::CNT_W-1:0]  i_choose,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [39:0]                 s_axis_tdata,
    input  wire logic [1:0]                  s_axis_tuser,
    input  wire logic                        i_full,
    output logic                             o_push,
    output cgen_pkg::t_job                   o_job
);
    import cgen_pkg::*;

    localparam int LIM = (MAX_POSITIONS < MASK_W) ? MAX_POSITIONS : MASK_W;
    localparam logic [CNT_W-1:0] LIM_N = CNT_W'(LIM);

    logic [MASK_W-1:0] r_sel_mask, n_sel_mask;
    logic              r_exhausted, n_exhausted;

    logic [CNT_W-1:0]  w_n, w_k, w_below_cnt;
    logic [MASK_W-1:0] w_m, w_pair, w_pair_oh, w_below, w_next_mask;
    logic [POS_W-1:0]  w_index;
    logic [DATA_W-1:0] w_value;
    logic              w_accept;

    assign s_axis_tready = !i_full;
    assign w_accept      = s_axis_tvalid && !i_full;
    assign w_index       = s_axis_tdata[3:0];
    assign w_value       = s_axis_tdata[35:4];

    always_comb begin
        w_n = (i_total == '0) ? CNT_W'(1) : i_total;
        if (w_n > LIM_N) begin
            w_n = LIM_N;
        end
        w_k = (i_choose == '0) ? CNT_W'(1) : i_choose;
        if (w_k > w_n) begin
            w_k = w_n;
        end
        w_m         = r_sel_mask & f_low_ones(w_n);
        w_pair      = w_m & ~(w_m >> 1) & f_low_ones(w_n - CNT_W'(1));
        w_pair_oh   = w_pair & (~w_pair + MASK_W'(1));
        w_below     = w_m & (w_pair_oh - MASK_W'(1));
        w_below_cnt = CNT_W'($countones(w_below));
        w_next_mask = (w_m & ~((w_pair_oh << 1) | w_pair_oh | (w_pair_oh - MASK_W'(1))))
                    | (w_pair_oh << 1) | f_low_ones(w_below_cnt);
    end

    always_comb begin
        o_push      = 1'b0;
        o_job.kind  = JOB_LOAD;
        o_job.index = w_index;
        o_job.value = w_value;
        o_job.mask  = '0;
        n_sel_mask  = r_sel_mask;
        n_exhausted = r_exhausted;
        if (w_accept) begin
            case (t_action'(s_axis_tuser))
                ACT_LOAD: begin
                    o_push = (32'(w_index) < 32'(MAX_POSITIONS));
                end
                ACT_RESTART: begin
                    o_push      = 1'b1;
                    o_job.kind  = JOB_EMIT;
                    o_job.mask  = f_low_ones(w_k);
                    n_sel_mask  = f_low_ones(w_k);
                    n_exhausted = 1'b0;
                end
                ACT_NEXT: begin
                    o_push = 1'b1;
                    if (!r_exhausted && (w_pair != '0)) begin
                        o_job.kind = JOB_EMIT;
                        o_job.mask = w_next_mask;
                        n_sel_mask = w_next_mask;
                    end else begin
                        o_job.kind  = JOB_DONE;
                        n_exhausted = 1'b1;
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_mask  <= '0;
            r_exhausted <= 1'b0;
        end else begin
            r_sel_mask  <= n_sel_mask;
            r_exhausted <= n_exhausted;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cgen_fifo.sv
// Short job queue between the front end and the back end.
// Depends on cgen_pkg for the job type and the queue depth.
`default_nettype none

module cgen_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cgen_pkg::t_job  i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output cgen_pkg::t_job       o_data,
    input  wire logic            i_pop
);
    import cgen_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/cgen_back.sv
// Back end: owns the value store and walks each subset mask, one result a cycle while the output is ready.
// Depends on cgen_pkg; takes jobs from cgen_fifo.
`default_nettype none

module cgen_back #(
    parameter int MAX_POSITIONS = cgen_pkg::DEF_MAX_POSITIONS,
    parameter int VALUE_BITS    = cgen_pkg::DEF_VALUE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  wire cgen_pkg::t_job               i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [cgen_pkg::POS_W-1:0]        o_pos,
    output logic [cgen_pkg::DATA_W-1:0]       o_element,
    output logic [cgen_pkg::MASK_W-1:0]       o_mask,
    output logic                              o_last,
    output logic                              o_done
);
    import cgen_pkg::*;

    localparam int AW = $clog2(MAX_POSITIONS);

    logic [VALUE_BITS-1:0] r_store [MAX_POSITIONS];
    logic [VALUE_BITS-1:0] r_rdata;

    t_back_state       r_state, n_state;
    logic [MASK_W-1:0] r_rem, r_mask;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_pos;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_last, r_done;

    logic              w_advance, w_emit, w_emit_done, w_write, w_last;
    logic [MASK_W-1:0] w_src, w_src_mask, w_lowbit, w_rest;
    logic [POS_W-1:0]  w_pos;

    assign w_advance = !r_out_valid || i_ready;
    assign w_src      = (r_state == BK_EMIT) ? r_rem  : i_job.mask;
    assign w_src_mask = (r_state == BK_EMIT) ? r_mask : i_job.mask;
    assign w_lowbit   = w_src & (~w_src + MASK_W'(1));
    assign w_rest     = w_src & ~w_lowbit;
    assign w_last     = (w_rest == '0);

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (w_lowbit[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_emit_done = 1'b0;
        w_write     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        JOB_LOAD: begin
                            w_write = 1'b1;
                            o_pop   = 1'b1;
                        end
                        JOB_EMIT: begin
                            if (w_advance) begin
                                w_emit = 1'b1;
                                o_pop  = 1'b1;
                                if (!w_last) begin
                                    n_state = BK_EMIT;
                                end
                            end
                        end
                        JOB_DONE: begin
                            if (w_advance) begin
                                w_emit_done = 1'b1;
                                o_pop       = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                if (w_advance) begin
                    w_emit = 1'b1;
                    if (w_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_store[AW'(i_job.index)] <= VALUE_BITS'(i_job.value);
        end
        if (w_emit) begin
            r_rdata <= r_store[AW'(w_pos)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_rem      <= w_rest;
            r_pos      <= w_pos;
            r_out_mask <= w_src_mask;
            r_last     <= w_last;
            r_done     <= 1'b0;
        end else if (w_emit_done) begin
            r_pos      <= '0;
            r_out_mask <= '0;
            r_last     <= 1'b0;
            r_done     <= 1'b1;
        end
        if (w_emit && (r_state == BK_IDLE)) begin
            r_mask <= i_job.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit || w_emit_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pos     = r_pos;
    assign o_element = r_done ? '0 : DATA_W'(r_rdata);
    assign o_mask    = r_out_mask;
    assign o_last    = r_last;
    assign o_done    = r_done;

endmodule

`default_nettype wire

// File: rtl/k_of_n_combination_generator_core.sv
// Top level of the k-of-n combination generator: register port, front end,
// job queue and back end. Depends on assert_macros.svh, cgen_pkg, cgen_front, cgen_fifo, cgen_back.
//
//   Channel   Direction  Content
//   s_axis    in         tuser: action; tdata: index [3:0], value [35:4]
//   m_axis    out        tuser: done; tlast: last; tdata: position, element, mask
//   apb       in/out     total_count at 0x0, choose_count at 0x4
//
// A restart or next request yields one result per selected position, one per cycle while m_axis
// is ready, as the back end walks the subset mask; a next request with no further subset yields a done result.
// The front end accepts a request in each cycle the two-entry job queue has room.
// A stalled output holds its result while the front end keeps filling the queue.
// Reset clears the mask, the exhausted flag, the queue and the output valid; the store is kept.
`default_nettype none
`include "assert_macros.svh"

module k_of_n_combination_generator_core #(
    parameter int MAX_POSITIONS = cgen_pkg::DEF_MAX_POSITIONS,
    parameter int VALUE_BITS    = cgen_pkg::DEF_VALUE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // index [3:0], value [35:4], zeros above
    input  wire logic [1:0]  s_axis_tuser,   // action [1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // position [3:0], element [35:4],
                                             // subset_mask [51:36], zeros above
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // done_res
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cgen_pkg::*;

    logic [CNT_W-1:0] r_total, r_choose;
    logic             w_cfg_we;

    logic             w_push, w_full, w_job_valid, w_pop;
    t_job             w_push_job, w_head_job;

    logic [POS_W-1:0]  w_out_pos;
    logic [DATA_W-1:0] w_out_element;
    logic [MASK_W-1:0] w_out_mask;
    logic              w_out_valid, w_out_last, w_out_done;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= TOTAL_RESET;
            r_choose <= CHOOSE_RESET;
        end else if (w_cfg_we) begin
            case (t_reg'(paddr[2]))
                REG_TOTAL:  r_total  <= pwdata[CNT_W-1:0];
                REG_CHOOSE: r_choose <= pwdata[CNT_W-1:0];
                default:    r_total  <= r_total;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_TOTAL:  prdata = 32'(r_total);
            REG_CHOOSE: prdata = 32'(r_choose);
            default:    prdata = '0;
        endcase
    end

    cgen_front #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_total       (r_total),
        .i_choose      (r_choose),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    cgen_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_data  (w_head_job),
        .i_pop   (w_pop)
    );

    cgen_back #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (w_out_valid),
        .i_ready     (m_axis_tready),
        .o_pos       (w_out_pos),
        .o_element   (w_out_element),
        .o_mask      (w_out_mask),
        .o_last      (w_out_last),
        .o_done      (w_out_done)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {4'd0, w_out_mask, w_out_element, w_out_pos};
    assign m_axis_tlast  = w_out_last;
    assign m_axis_tuser  = w_out_done;

    `ASSERT_IMP(a_done_is_bare, i_clk, i_rst_n, w_out_valid && w_out_done, !w_out_last && (w_out_mask == '0), "done result carries an element")
    `ASSERT_IMP(a_pos_selected, i_clk, i_rst_n, w_out_valid && !w_out_done, w_out_mask[w_out_pos], "emitted position is not in the subset mask")
    `ASSERT_IMP(a_last_is_top, i_clk, i_rst_n, w_out_valid && !w_out_done && w_out_last, (w_out_mask >> w_out_pos) == MASK_W'(1), "last flag set below the top selected position")
    `ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_push, !w_full, "job pushed into a full queue")

endmodule

`default_nettype wire

// File: tb/sv/tb_k_of_n_combination_generator_core.sv
// Self-checking testbench for the k-of-n combination generator core.
// A predictor tracks the value store, subset mask and exhausted flag, and checks each
// streamed element. It depends on cgen_pkg and k_of_n_combination_generator_core.
`default_nettype none

module tb_k_of_n_combination_generator_core;
    import cgen_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_REQS   = 28;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  index;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        logic [3:0]  position;
        logic [31:0] element;
        logic [15:0] mask;
        logic        last;
        logic        done;
    } t_subset_elem;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] elem_store [16];
    logic [15:0] sel_mask    = '0;
    logic        exhausted   = 1'b0;
    logic [4:0]  total_cfg   = TOTAL_RESET;
    logic [4:0]  choose_cfg  = CHOOSE_RESET;

    t_request     pending_q [$];
    t_subset_elem expected_q [$];
    t_request     cur_req = '0;

    int pushed_cnt   = 0;
    int accepted_cnt = 0;
    int fail_cnt     = 0;
    int quiet_cycles = 0;
    int snd_idle_pct = 31;
    int rcv_idle_pct = 52;

    int total_set  [NUM_PHASES] = '{16, 0, 31, 4, 6, 5, 16, 3, 10, 2, 1, 7};
    int choose_set [NUM_PHASES] = '{16, 0, 31, 2, 3, 31, 8, 1, 4, 1, 1, 3};

    k_of_n_combination_generator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] ones_below(int c);
        if (c >= 16) begin
            return 16'hFFFF;
        end
        return (16'd1 << c) - 16'd1;
    endfunction

    function automatic int active_positions();
        int n;
        n = int'(total_cfg);
        if (n == 0) begin
            n = 1;
        end
        if (n > 16) begin
            n = 16;
        end
        return n;
    endfunction

    function automatic int subset_size(int n);
        int k;
        k = int'(choose_cfg);
        if (k == 0) begin
            k = 1;
        end
        if (k > n) begin
            k = n;
        end
        return k;
    endfunction

    task automatic emit_subset(int n);
        logic [15:0] m;
        int p;
        m = sel_mask & ones_below(n);
        for (p = 0; p < n; p++) begin
            if (m[p]) begin
                expected_q.push_back('{position: 4'(p), element: elem_store[p], mask: m,
                                       last: ((m >> (p + 1)) == 16'd0), done: 1'b0});
            end
        end
    endtask

    task automatic advance_generator(t_request req);
        int n;
        int i;
        int below;
        logic [15:0] m;
        bit found;
        n = active_positions();
        case (req.action)
            ACT_LOAD: begin
                elem_store[req.index] = req.value;
            end
            ACT_RESTART: begin
                sel_mask = ones_below(subset_size(n));
                exhausted = 1'b0;
                emit_subset(n);
            end
            ACT_NEXT: begin
                m = sel_mask & ones_below(n);
                found = 1'b0;
                if (!exhausted) begin
                    for (i = 0; i + 1 < n && !found; i++) begin
                        if (m[i] && !m[i+1]) begin
                            below = $countones(m & ones_below(i));
                            sel_mask = (m & ~ones_below(i + 2)) | (16'd1 << (i + 1))
                                     | ones_below(below);
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    emit_subset(n);
                end else begin
                    exhausted = 1'b1;
                    expected_q.push_back('{position: '0, element: '0, mask: '0,
                                           last: 1'b0, done: 1'b1});
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_generator(cur_req);
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    cur_req = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, cur_req.value, cur_req.index};
                    s_axis_tuser  <= cur_req.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_subset_elem got;
        t_subset_elem want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{position: m_axis_tdata[3:0], element: m_axis_tdata[35:4],
                    mask: m_axis_tdata[51:36], last: m_axis_tlast, done: m_axis_tuser};
            if (expected_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS) begin
                    $display("%0t: unexpected element, expected none, got pos %0d elem %h %s",
                             $time, got.position, got.element,
                             $sformatf("mask %h last %b done %b", got.mask, got.last, got.done));
                end
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("%0t: element mismatch, expected %s, got %s", $time,
                                 $sformatf("pos %0d elem %h mask %h last %b done %b",
                                           want.position, want.element, want.mask,
                                           want.last, want.done),
                                 $sformatf("pos %0d elem %h mask %h last %b done %b",
                                           got.position, got.element, got.mask,
                                           got.last, got.done));
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_request(logic [1:0] action, logic [3:0] index, logic [31:0] value);
        pending_q.push_back('{action: action, index: index, value: value});
        pushed_cnt++;
    endtask

    task automatic wait_results(int extra);
        while (accepted_cnt != pushed_cnt || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [4:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {27'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == REG_TOTAL) begin
            total_cfg = val;
        end else begin
            choose_cfg = val;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int ph;
        int r;
        int sel;
        int i;
        logic [31:0] v;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A next request before any restart sees an empty mask, twice in a row.
        queue_request(ACT_NEXT, 4'd0, 32'd0);
        queue_request(ACT_NEXT, 4'hF, 32'hFFFFFFFF);
        for (i = 0; i < 16; i++) begin
            case (i)
                0: v = 32'h80000000;
                1: v = 32'h7FFFFFFF;
                2: v = 32'h00000000;
                3: v = 32'hFFFFFFFF;
                4: v = 32'h00000001;
                5: v = 32'hAAAAAAAA;
                6: v = 32'h55555555;
                default: v = $urandom();
            endcase
            queue_request(ACT_LOAD, 4'(15 - i), v);
        end
        queue_request(ACT_RESTART, 4'd0, 32'd0);
        queue_request(ACT_NEXT, 4'd0, 32'd0);
        queue_request(ACT_UNUSED, 4'hA, 32'h12345678);
        queue_request(ACT_NEXT, 4'd0, 32'd0);
        queue_request(ACT_RESTART, 4'd0, 32'd0);
        wait_results(DRAIN_CYCLES);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 4)
                0: begin
                    snd_idle_pct = 31;
                    rcv_idle_pct = 52;
                end
                1: begin
                    snd_idle_pct = 52;
                    rcv_idle_pct = 31;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            write_reg(REG_TOTAL, 5'(total_set[ph]));
            write_reg(REG_CHOOSE, 5'(choose_set[ph]));
            // Odd phases continue the enumeration left over from the previous setting.
            queue_request((ph % 2 == 0) ? ACT_RESTART : ACT_NEXT, 4'($urandom()), $urandom());
            r = 1;
            while (r < PHASE_REQS) begin
                if (ph % 4 == 1 && r == PHASE_REQS / 2) begin
                    wait_results(0);
                end
                sel = $urandom_range(0, 99);
                if (sel < 12) begin
                    queue_request(ACT_LOAD, 4'($urandom_range(0, 15)), $urandom());
                    r++;
                end else if (sel < 20) begin
                    queue_request(ACT_RESTART, 4'($urandom()), $urandom());
                    r++;
                end else if (sel < 95) begin
                    queue_request(ACT_NEXT, 4'($urandom()), $urandom());
                    r++;
                end else begin
                    queue_request(ACT_UNUSED, 4'($urandom()), $urandom());
                end
            end
            wait_results(DRAIN_CYCLES);
        end

        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: k_of_n_combination_generator_core.f
+incdir+rtl
rtl/cgen_pkg.sv
rtl/cgen_front.sv
rtl/cgen_fifo.sv
rtl/cgen_back.sv
rtl/k_of_n_combination_generator_core.sv
tb/sv/tb_k_of_n_combination_generator_core.sv
